// File: hdl/rmt_pkg.sv
// Package for the ring membership table: opcodes, status codes, sizes.
// Used by the top level; depends on nothing.
package rmt_pkg;
   localparam int RINGS_PER_SIZE_DEF = 64;
   localparam int ATOM_BITS_DEF      = 12;
   localparam int RING_SLOTS         = 6;
   localparam int OUT_ATOM_BITS      = 12;

   localparam logic [2:0] OP_CLEAR    = 3'd0;
   localparam logic [2:0] OP_INSERT   = 3'd1;
   localparam logic [2:0] OP_CONTAINS = 3'd2;
   localparam logic [2:0] OP_COUNT    = 3'd3;
   localparam logic [2:0] OP_FETCH    = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_DUP   = 2'd2;
endpackage

// File: hdl/rmt_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module rmt_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_data <= mem_ff[addr];
   end
endmodule

// File: hdl/ring_membership_table_top.sv
// Top level of the ring membership table: sequencer, ring store, compare unit.
// Depends on rmt_pkg and rmt_ram.
//
//  channel | direction | ports
//  req_    | in        | opcode, ring_size, atom_count, atom_a..f, occurrence
//  rsp_    | out       | hit, occ_count, ring_atom_a..f, status
//
// Each word is handled alone. The store is one wide RAM word per ring (six
// slots), read once per cycle, so a query walks the stored rings of one size
// at one ring a cycle.
// Insert first sorts in six transposition passes, then walks, then writes
// unless a duplicate is found or the size is full; clear and bad words skip both.
// Reset is synchronous and clears the ring counts; the store needs none.
// A result waits in the output register while rsp_stall is high.
module ring_membership_table_top #(
   parameter int RINGS_PER_SIZE = rmt_pkg::RINGS_PER_SIZE_DEF,
   parameter int ATOM_BITS      = rmt_pkg::ATOM_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [2:0]  req_ring_size,
   input  logic [2:0]  req_atom_count,
   input  logic [11:0] req_atom_a,
   input  logic [11:0] req_atom_b,
   input  logic [11:0] req_atom_c,
   input  logic [11:0] req_atom_d,
   input  logic [11:0] req_atom_e,
   input  logic [11:0] req_atom_f,
   input  logic [8:0]  req_occurrence,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [8:0]  rsp_occ_count,
   output logic [11:0] rsp_ring_atom_a,
   output logic [11:0] rsp_ring_atom_b,
   output logic [11:0] rsp_ring_atom_c,
   output logic [11:0] rsp_ring_atom_d,
   output logic [11:0] rsp_ring_atom_e,
   output logic [11:0] rsp_ring_atom_f,
   output logic [1:0]  rsp_status
);
   localparam int SLOTS   = rmt_pkg::RING_SLOTS;
   localparam int CW      = $clog2(RINGS_PER_SIZE + 1);
   localparam int RW      = (RINGS_PER_SIZE > 1) ? $clog2(RINGS_PER_SIZE) : 1;
   localparam int DEPTH   = 4 * RINGS_PER_SIZE;
   localparam int AW      = $clog2(DEPTH);
   localparam int WW      = SLOTS * ATOM_BITS;
   localparam int OB      = rmt_pkg::OUT_ATOM_BITS;
   localparam int KB      = (ATOM_BITS < OB) ? ATOM_BITS : OB;

   typedef enum logic [2:0] {S_IDLE, S_SORT, S_WALK, S_WRITE, S_DONE} state_type;
   typedef logic [ATOM_BITS-1:0] atom_type;

   state_type      state_ff;
   logic [2:0]     op_ff, size_ff, acnt_ff;
   logic [1:0]     tbl_ff;
   atom_type       q_ff [SLOTS];
   logic [8:0]     occ_ff, seen_ff;
   logic [CW-1:0]  cnt_ff [4];
   logic [CW-1:0]  lim_ff;
   logic [CW-1:0]  rd_ptr_ff;   // next ring to issue
   logic           rd_vld_ff;
   logic [2:0]     sort_ff;
   logic           found_ff;

   logic           hit_ff;
   logic [8:0]     occ_cnt_ff;
   atom_type       ra_ff [SLOTS];
   logic [1:0]     status_ff;
   logic           rsp_valid_ff;

   logic           wr_en;
   logic [AW-1:0]  addr;
   logic [WW-1:0]  wr_data, rd_data;
   atom_type       ring [SLOTS];

   rmt_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_store (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(wr_data),
      .rd_data(rd_data)
   );

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         ring[i]                         = rd_data[i*ATOM_BITS +: ATOM_BITS];
         wr_data[i*ATOM_BITS +: ATOM_BITS] = q_ff[i];
      end
   end

   assign wr_en = (state_ff == S_WRITE);
   always_comb begin
      if (state_ff == S_WRITE)
         addr = AW'(({2'b00, tbl_ff} * RINGS_PER_SIZE) + lim_ff[RW-1:0]);
      else
         addr = AW'(({2'b00, tbl_ff} * RINGS_PER_SIZE) + rd_ptr_ff[RW-1:0]);
   end

   // shared compare unit: one ring against the query per cycle
   logic           eq_all;
   logic           holds;
   logic [2:0]     nmatch;
   logic [8:0]     seen_pre [SLOTS+1];
   logic           fetch_hit;
   always_comb begin
      logic [SLOTS-1:0] used;
      logic             got, ok;
      eq_all = 1'b1;
      nmatch = '0;
      used   = '0;
      ok     = 1'b1;
      fetch_hit = 1'b0;
      seen_pre[0] = seen_ff;
      for (int p = 0; p < SLOTS; p++) begin
         if (p < size_ff && ring[p] != q_ff[p]) eq_all = 1'b0;
         if (p < size_ff && ring[p] == q_ff[0]) begin
            nmatch = nmatch + 3'd1;
            if (seen_pre[p] == occ_ff) fetch_hit = 1'b1;
            seen_pre[p+1] = seen_pre[p] + 9'd1;
         end else begin
            seen_pre[p+1] = seen_pre[p];
         end
      end
      for (int i = 0; i < SLOTS; i++) begin
         got = 1'b0;
         if (i < acnt_ff) begin
            for (int p = 0; p < SLOTS; p++) begin
               if (!got && p < size_ff && !used[p] && ring[p] == q_ff[i]) begin
                  used[p] = 1'b1;
                  got     = 1'b1;
               end
            end
            if (!got) ok = 1'b0;
         end
      end
      holds = ok;
   end

   // one odd-even transposition step on the query atoms
   atom_type sorted [SLOTS];
   always_comb begin
      for (int i = 0; i < SLOTS; i++) sorted[i] = q_ff[i];
      for (int i = 0; i + 1 < SLOTS; i++) begin
         if ((i % 2) == int'(sort_ff[0]) && (i + 1) < size_ff &&
             q_ff[i] > q_ff[i+1]) begin
            sorted[i]   = q_ff[i+1];
            sorted[i+1] = q_ff[i];
         end
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_occ_count   = occ_cnt_ff;
   assign rsp_status      = status_ff;
   assign rsp_ring_atom_a = OB'(ra_ff[0]);
   assign rsp_ring_atom_b = OB'(ra_ff[1]);
   assign rsp_ring_atom_c = OB'(ra_ff[2]);
   assign rsp_ring_atom_d = OB'(ra_ff[3]);
   assign rsp_ring_atom_e = OB'(ra_ff[4]);
   assign rsp_ring_atom_f = OB'(ra_ff[5]);

   logic walk_end;
   assign walk_end = !rd_vld_ff && (rd_ptr_ff >= lim_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < 4; t++) cnt_ff[t] <= '0;
      end else begin
         case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_ff   <= req_opcode;
               size_ff <= req_ring_size;
               acnt_ff <= req_atom_count;
               tbl_ff  <= 2'(req_ring_size - 3'd3);
               occ_ff  <= req_occurrence;
               q_ff[0] <= ATOM_BITS'(req_atom_a);
               q_ff[1] <= ATOM_BITS'(req_atom_b);
               q_ff[2] <= ATOM_BITS'(req_atom_c);
               q_ff[3] <= ATOM_BITS'(req_atom_d);
               q_ff[4] <= ATOM_BITS'(req_atom_e);
               q_ff[5] <= ATOM_BITS'(req_atom_f);
               lim_ff  <= cnt_ff[2'(req_ring_size - 3'd3)];
               hit_ff  <= 1'b0;
               occ_cnt_ff <= '0;
               status_ff  <= rmt_pkg::ST_OK;
               for (int i = 0; i < SLOTS; i++) ra_ff[i] <= '0;
               seen_ff    <= '0;
               found_ff   <= 1'b0;
               rd_ptr_ff  <= '0;
               rd_vld_ff  <= 1'b0;
               sort_ff    <= '0;
               if (req_opcode == rmt_pkg::OP_CLEAR) begin
                  for (int t = 0; t < 4; t++) cnt_ff[t] <= '0;
                  state_ff <= S_DONE;
               end else if (req_opcode > rmt_pkg::OP_FETCH ||
                            req_ring_size < 3'd3 || req_ring_size > 3'd6) begin
                  state_ff <= S_DONE;
               end else if (req_opcode == rmt_pkg::OP_CONTAINS &&
                            (req_atom_count == 3'd0 ||
                             req_atom_count > req_ring_size)) begin
                  state_ff <= S_DONE;
               end else if (req_opcode == rmt_pkg::OP_INSERT) begin
                  state_ff <= S_SORT;
               end else begin
                  state_ff <= S_WALK;
               end
            end
         end
         S_SORT: begin
            // six transposition passes sort up to six atoms
            for (int i = 0; i < SLOTS; i++) q_ff[i] <= sorted[i];
            sort_ff <= sort_ff + 3'd1;
            if (sort_ff == 3'd5) state_ff <= S_WALK;
         end
         S_WALK: begin
            // advance the read pointer, compare the ring returned last cycle
            rd_vld_ff <= (rd_ptr_ff < lim_ff) && !found_ff;
            if (rd_ptr_ff < lim_ff) rd_ptr_ff <= rd_ptr_ff + 1'b1;
            if (rd_vld_ff && !found_ff) begin
               case (op_ff)
               rmt_pkg::OP_INSERT: begin
                  if (eq_all) begin
                     found_ff  <= 1'b1;
                     status_ff <= rmt_pkg::ST_DUP;
                  end
               end
               rmt_pkg::OP_CONTAINS: begin
                  if (holds) begin
                     found_ff <= 1'b1;
                     hit_ff   <= 1'b1;
                  end
               end
               rmt_pkg::OP_COUNT: begin
                  if (occ_cnt_ff + 9'(nmatch) < occ_cnt_ff || occ_cnt_ff + 9'(nmatch) > 9'd511)
                     occ_cnt_ff <= 9'd511;
                  else
                     occ_cnt_ff <= occ_cnt_ff + 9'(nmatch);
               end
               rmt_pkg::OP_FETCH: begin
                  if (fetch_hit) begin
                     found_ff <= 1'b1;
                     hit_ff   <= 1'b1;
                     for (int k = 0; k < SLOTS; k++)
                        ra_ff[k] <= (k < size_ff) ? atom_type'(ring[k] &
                                    atom_type'({KB{1'b1}})) : '0;
                  end else begin
                     seen_ff <= seen_pre[SLOTS];
                  end
               end
               default: ;
               endcase
            end
            if ((walk_end || (found_ff && !rd_vld_ff)) ) begin
               if (op_ff == rmt_pkg::OP_INSERT && !found_ff) begin
                  if (lim_ff >= CW'(RINGS_PER_SIZE)) begin
                     status_ff <= rmt_pkg::ST_FULL;
                     state_ff  <= S_DONE;
                  end else begin
                     state_ff <= S_WRITE;
                  end
               end else begin
                  state_ff <= S_DONE;
               end
            end
         end
         S_WRITE: begin
            cnt_ff[tbl_ff] <= lim_ff + 1'b1;
            state_ff <= S_DONE;
         end
         S_DONE: begin
            // hold the word until taken
            if (!rsp_valid_ff) begin
               rsp_valid_ff <= 1'b1;
            end else if (!rsp_stall) begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
         end
         default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
